// ===== hw/rtl/irclep_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, keyword tables and codes for the IRC line event parser.
package irclep_pkg;

    // Width of the per-field byte counter
    localparam int CNT_W = 9;

    typedef struct packed {
        logic [7:0] char_in;
        logic       end_of_line;
    } in_t;

    typedef struct packed {
        logic       is_verdict;
        logic [1:0] field_tag;
        logic [7:0] field_byte;
        logic       accepted;
        logic [3:0] event_kind;
        logic       target_replaced;
        logic       run_end;
    } out_t;

    // Words handed from the parse step to the result queue
    typedef struct packed {
        logic [1:0] count;
        out_t       first;
        out_t       second;
    } push_t;

    typedef enum logic [9:0] {
        PH_START    = 10'b00_0000_0001,
        PH_PFX_NICK = 10'b00_0000_0010,
        PH_PFX_REST = 10'b00_0000_0100,
        PH_CMD_SKIP = 10'b00_0000_1000,
        PH_CMD_WORD = 10'b00_0001_0000,
        PH_PAR_SKIP = 10'b00_0010_0000,
        PH_TARGET   = 10'b00_0100_0000,
        PH_TRL_SKIP = 10'b00_1000_0000,
        PH_TRAIL    = 10'b01_0000_0000,
        PH_DONE     = 10'b10_0000_0000
    } phase_t;

    localparam logic [1:0] TAG_NICK   = 2'd0;
    localparam logic [1:0] TAG_TARGET = 2'd1;
    localparam logic [1:0] TAG_TEXT   = 2'd2;
    localparam logic [1:0] TAG_RENAME = 2'd3;

    localparam logic [3:0] KIND_NONE = 4'd0;
    localparam logic [3:0] KIND_NICK = 4'd8;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_COLON = ":";
    localparam logic [7:0] CH_BANG  = "!";
    localparam logic [7:0] CH_SPACE = " ";

    localparam logic [7:0] KW_TEXT [8][8] = '{
        '{"P", "R", "I", "V", "M", "S", "G", 8'h00},
        '{"N", "O", "T", "I", "C", "E", 8'h00, 8'h00},
        '{"J", "O", "I", "N", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"P", "A", "R", "T", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"Q", "U", "I", "T", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"K", "I", "C", "K", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"T", "O", "P", "I", "C", 8'h00, 8'h00, 8'h00},
        '{"N", "I", "C", "K", 8'h00, 8'h00, 8'h00, 8'h00}
    };

    localparam logic [3:0] KW_LEN [8] = '{4'd7, 4'd6, 4'd4, 4'd4, 4'd4, 4'd4, 4'd5, 4'd4};

    // First surviving keyword whose length equals the word length; 0 if none
    function automatic logic [3:0] command_kind(logic [7:0] mask, logic [3:0] pos);
        logic [3:0] kind;
        kind = KIND_NONE;
        for (int i = 7; i >= 0; i--) begin
            if (mask[i] && KW_LEN[i] == pos) begin
                kind = 4'(i + 1);
            end
        end
        return kind;
    endfunction

endpackage

// ===== hw/rtl/irc_line_event_parser.sv =====
`timescale 1ns / 1ps
// Top level of the IRC line event parser: input register, parse step, result queue.
//
//  Channel | Ports                       | Word
//  --------+-----------------------------+-------------------------------------------
//  input   | s_valid, s_ready, s_data    | one line byte plus end-of-line flag
//  result  | m_valid, m_ready, m_data    | one field byte or one end-of-line verdict
//
// One byte per cycle through the parse step; a new word is taken every cycle while
// the result queue has room for two words. A byte yields zero, one or two result
// words, and the result port drains one word per cycle. Result words are held in
// the result queue before they can be taken. Reset (aresetn low, synchronous)
// returns the parser to line start and empties the queue. A stalled result port
// holds the queue, and the input stalls once fewer than two entries are free.
module irc_line_event_parser #(
    parameter int NICK_LEN   = 32,
    parameter int TARGET_LEN = 64,
    parameter int TEXT_LEN   = 256
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  irclep_pkg::in_t  s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output irclep_pkg::out_t m_data
);

    logic              in_valid_reg, in_valid_next;
    irclep_pkg::in_t   in_data_reg;
    logic              room;
    logic              step;
    logic              take;
    irclep_pkg::push_t push;

    // Advance the held byte whenever the queue can take both possible words
    assign step    = in_valid_reg && room;
    // Take a new word whenever the input register is empty or drains this cycle
    assign s_ready = !in_valid_reg || step;
    assign take    = s_valid && s_ready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (take) begin
            in_valid_next = 1'b1;
        end else if (step) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    // Payload register needs no reset
    always_ff @(posedge aclk) begin
        if (take) begin
            in_data_reg <= s_data;
        end
    end

    irclep_core #(
        .NICK_LEN   (NICK_LEN),
        .TARGET_LEN (TARGET_LEN),
        .TEXT_LEN   (TEXT_LEN)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .item    (in_data_reg),
        .push    (push)
    );

    irclep_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .room    (room),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// ===== hw/rtl/irclep_core.sv =====
`timescale 1ns / 1ps
// Parse state registers and the one-byte parse step.
module irclep_core #(
    parameter int NICK_LEN   = 32,
    parameter int TARGET_LEN = 64,
    parameter int TEXT_LEN   = 256
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            step,
    input  irclep_pkg::in_t item,
    output irclep_pkg::push_t push
);

    localparam logic [irclep_pkg::CNT_W-1:0] NICK_LIM   = irclep_pkg::CNT_W'(NICK_LEN - 1);
    localparam logic [irclep_pkg::CNT_W-1:0] TARGET_LIM = irclep_pkg::CNT_W'(TARGET_LEN - 1);
    localparam logic [irclep_pkg::CNT_W-1:0] TEXT_LIM   = irclep_pkg::CNT_W'(TEXT_LEN - 1);

    irclep_pkg::phase_t             phase_reg, phase_next;
    logic [7:0]                     mask_reg, mask_next;
    logic [3:0]                     pos_reg, pos_next;
    logic [irclep_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic [3:0]                     kind_reg, kind_next;
    logic                           tseen_reg, tseen_next;

    logic                           stop;
    logic                           want_f;
    logic [1:0]                     want_tag;
    logic [irclep_pkg::CNT_W-1:0]   want_lim;
    logic                           emit_f;
    irclep_pkg::out_t               f_item;
    irclep_pkg::out_t               v_item;
    logic [7:0]                     c;

    always_comb begin
        c          = item.char_in;
        phase_next = phase_reg;
        mask_next  = mask_reg;
        pos_next   = pos_reg;
        cnt_next   = cnt_reg;
        kind_next  = kind_reg;
        tseen_next = tseen_reg;
        stop       = 1'b0;
        want_f     = 1'b0;
        want_tag   = irclep_pkg::TAG_NICK;
        want_lim   = NICK_LIM;
        emit_f     = 1'b0;

        if (phase_next != irclep_pkg::PH_DONE && c == irclep_pkg::CH_NUL) begin
            // Zero byte ends the line content
            if (phase_next == irclep_pkg::PH_CMD_WORD) begin
                kind_next = irclep_pkg::command_kind(mask_next, pos_next);
            end else if (phase_next == irclep_pkg::PH_START ||
                         phase_next == irclep_pkg::PH_CMD_SKIP ||
                         phase_next == irclep_pkg::PH_PFX_NICK ||
                         phase_next == irclep_pkg::PH_PFX_REST) begin
                kind_next = irclep_pkg::KIND_NONE;
            end
            phase_next = irclep_pkg::PH_DONE;
            stop       = 1'b1;
        end else if (phase_next == irclep_pkg::PH_DONE) begin
            stop = 1'b1;
        end

        if (!stop && phase_next == irclep_pkg::PH_START) begin
            if (c == irclep_pkg::CH_COLON) begin
                phase_next = irclep_pkg::PH_PFX_NICK;
                stop       = 1'b1;
            end else begin
                phase_next = irclep_pkg::PH_CMD_SKIP;
            end
        end

        if (!stop && (phase_next == irclep_pkg::PH_PFX_NICK ||
                      phase_next == irclep_pkg::PH_PFX_REST)) begin
            if (c == irclep_pkg::CH_SPACE) begin
                cnt_next   = '0;
                phase_next = irclep_pkg::PH_CMD_SKIP;
            end else if (phase_next == irclep_pkg::PH_PFX_NICK) begin
                if (c == irclep_pkg::CH_BANG) begin
                    phase_next = irclep_pkg::PH_PFX_REST;
                end else begin
                    want_f   = 1'b1;
                    want_tag = irclep_pkg::TAG_NICK;
                    want_lim = NICK_LIM;
                end
            end
            stop = 1'b1;
        end

        if (!stop && phase_next == irclep_pkg::PH_CMD_SKIP) begin
            if (c == irclep_pkg::CH_SPACE) begin
                stop = 1'b1;
            end else begin
                phase_next = irclep_pkg::PH_CMD_WORD;
            end
        end

        if (!stop && phase_next == irclep_pkg::PH_CMD_WORD) begin
            if (c == irclep_pkg::CH_SPACE) begin
                kind_next  = irclep_pkg::command_kind(mask_next, pos_next);
                phase_next = (kind_next == irclep_pkg::KIND_NONE) ?
                             irclep_pkg::PH_DONE : irclep_pkg::PH_PAR_SKIP;
            end else begin
                // Drop every keyword that is too short or differs here
                for (int i = 0; i < 8; i++) begin
                    if (pos_reg >= irclep_pkg::KW_LEN[i] ||
                        irclep_pkg::KW_TEXT[i][pos_reg[2:0]] != c) begin
                        mask_next[i] = 1'b0;
                    end
                end
                if (pos_reg != 4'd15) begin
                    pos_next = pos_reg + 4'd1;
                end
            end
            stop = 1'b1;
        end

        if (!stop && phase_next == irclep_pkg::PH_PAR_SKIP) begin
            if (c == irclep_pkg::CH_SPACE) begin
                stop = 1'b1;
            end else begin
                cnt_next = '0;
                if (c == irclep_pkg::CH_COLON) begin
                    tseen_next = 1'b1;
                    phase_next = irclep_pkg::PH_TRAIL;
                    stop       = 1'b1;
                end else begin
                    phase_next = irclep_pkg::PH_TARGET;
                end
            end
        end

        if (!stop && phase_next == irclep_pkg::PH_TARGET) begin
            if (c == irclep_pkg::CH_SPACE) begin
                phase_next = irclep_pkg::PH_TRL_SKIP;
            end else begin
                want_f   = 1'b1;
                want_tag = irclep_pkg::TAG_TARGET;
                want_lim = TARGET_LIM;
            end
            stop = 1'b1;
        end

        if (!stop && phase_next == irclep_pkg::PH_TRL_SKIP) begin
            if (c == irclep_pkg::CH_SPACE) begin
                stop = 1'b1;
            end else begin
                tseen_next = 1'b1;
                cnt_next   = '0;
                phase_next = irclep_pkg::PH_TRAIL;
                if (c == irclep_pkg::CH_COLON) begin
                    stop = 1'b1;
                end
            end
        end

        if (!stop && phase_next == irclep_pkg::PH_TRAIL) begin
            want_f = 1'b1;
            if (kind_next == irclep_pkg::KIND_NICK) begin
                want_tag = irclep_pkg::TAG_RENAME;
                want_lim = TARGET_LIM;
            end else begin
                want_tag = irclep_pkg::TAG_TEXT;
                want_lim = TEXT_LIM;
            end
        end

        // Truncate each field to its limit
        if (want_f && cnt_next < want_lim) begin
            emit_f   = 1'b1;
            cnt_next = cnt_next + irclep_pkg::CNT_W'(1);
        end

        // End of line: settle the kind if still open
        if (item.end_of_line && phase_next != irclep_pkg::PH_DONE) begin
            if (phase_next == irclep_pkg::PH_CMD_WORD) begin
                kind_next = irclep_pkg::command_kind(mask_next, pos_next);
            end else if (phase_next == irclep_pkg::PH_START ||
                         phase_next == irclep_pkg::PH_CMD_SKIP ||
                         phase_next == irclep_pkg::PH_PFX_NICK ||
                         phase_next == irclep_pkg::PH_PFX_REST) begin
                kind_next = irclep_pkg::KIND_NONE;
            end
        end

        f_item                 = '0;
        f_item.field_tag       = want_tag;
        f_item.field_byte      = c;
        f_item.run_end         = !item.end_of_line;

        v_item                 = '0;
        v_item.is_verdict      = 1'b1;
        v_item.accepted        = (kind_next != irclep_pkg::KIND_NONE);
        v_item.event_kind      = kind_next;
        v_item.target_replaced = (kind_next == irclep_pkg::KIND_NICK) && tseen_next;
        v_item.run_end         = 1'b1;

        push.count  = {1'b0, emit_f} + {1'b0, item.end_of_line};
        push.first  = emit_f ? f_item : v_item;
        push.second = v_item;

        if (item.end_of_line) begin
            // Clear for the next line
            phase_next = irclep_pkg::PH_START;
            mask_next  = 8'hFF;
            pos_next   = '0;
            cnt_next   = '0;
            kind_next  = irclep_pkg::KIND_NONE;
            tseen_next = 1'b0;
        end

        if (!step) begin
            push.count = 2'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= irclep_pkg::PH_START;
            mask_reg  <= 8'hFF;
            pos_reg   <= '0;
            cnt_reg   <= '0;
            kind_reg  <= irclep_pkg::KIND_NONE;
            tseen_reg <= 1'b0;
        end else if (step) begin
            phase_reg <= phase_next;
            mask_reg  <= mask_next;
            pos_reg   <= pos_next;
            cnt_reg   <= cnt_next;
            kind_reg  <= kind_next;
            tseen_reg <= tseen_next;
        end
    end

endmodule

// ===== hw/rtl/irclep_queue.sv =====
`timescale 1ns / 1ps
// Four-word result queue taking up to two words per cycle.
module irclep_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  irclep_pkg::push_t  push,
    output logic               room,
    output logic               m_valid,
    input  logic               m_ready,
    output irclep_pkg::out_t   m_data
);

    irclep_pkg::out_t entry_reg [4];
    logic [1:0]       wr_ptr_reg, wr_ptr_next;
    logic [1:0]       rd_ptr_reg, rd_ptr_next;
    logic [2:0]       count_reg, count_next;
    logic             pop;

    assign m_valid = (count_reg != 3'd0);
    assign m_data  = entry_reg[rd_ptr_reg];
    assign pop     = m_valid && m_ready;
    // Room for two words regardless of this cycle's pop
    assign room    = (count_reg <= 3'd2);

    always_comb begin
        wr_ptr_next = wr_ptr_reg + push.count;
        rd_ptr_next = rd_ptr_reg + {1'b0, pop};
        count_next  = count_reg + {1'b0, push.count} - {2'b00, pop};
    end

    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) begin
            entry_reg[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2) begin
            entry_reg[wr_ptr_reg + 2'd1] <= push.second;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== tb/sv/irc_line_event_parser_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the IRC line event parser: random lines, stalls, scoreboard.
module irc_line_event_parser_test;
    import irclep_pkg::*;

    localparam int NICK_LEN    = 32;
    localparam int TARGET_LEN  = 64;
    localparam int TEXT_LEN    = 256;
    // Total bytes to offer, directed lines included, before random lines stop
    localparam int RANDOM_BYTES = 1700;
    // Idle cycles (nothing accepted on either side) that count as a hang
    localparam int STALL_LIMIT  = 3000;
    // Cycles to keep watching the result port once the scoreboard is empty
    localparam int DRAIN_CYCLES = 16;
    // Received words after which the receiver holds off for one long stretch
    localparam int HOLD_AT      = 400;
    localparam int HOLD_CYCLES  = 400;
    localparam logic [3:0] CMD_POS_MAX = 4'd15;
    // Keywords right-aligned in 7 bytes, in event-kind order (kind = index + 1)
    localparam logic [55:0] KW_NAME [8] = '{"PRIVMSG", "NOTICE", "JOIN", "PART",
                                             "QUIT", "KICK", "TOPIC", "NICK"};
    localparam int KW_SIZE [8] = '{7, 6, 4, 4, 4, 4, 5, 4};

    logic aclk;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t  s_data  = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;

    irc_line_event_parser #(
        .NICK_LEN   (NICK_LEN),
        .TARGET_LEN (TARGET_LEN),
        .TEXT_LEN   (TEXT_LEN)
    ) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Stimulus and scoreboard storage
    in_t        line_stream[$];      // words waiting to be offered
    logic [7:0] line_buf[$];         // line under construction
    out_t       event_words_due[$];  // predicted result words, oldest first
    int         stim_bytes = 0;
    int         err_cnt = 0;
    int         words_rcvd = 0;
    logic       byte_taken = 1'b0;   // input handshake seen at the last rising edge

    // Shadow parser state
    phase_t          ph;
    logic [7:0]      kw_mask;
    logic [3:0]      cmd_pos;
    logic [CNT_W-1:0] fld_cnt;
    logic [3:0]      kind_sel;
    logic            trail_seen;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Shadow parser: mirrors the line decode one byte at a time
    // ------------------------------------------------------------------

    task automatic rewind_line();
        ph         = PH_START;
        kw_mask    = 8'hFF;
        cmd_pos    = '0;
        fld_cnt    = '0;
        kind_sel   = KIND_NONE;
        trail_seen = 1'b0;
    endtask

    // First keyword still alive whose length equals the command length
    function automatic logic [3:0] match_keyword();
        for (int i = 0; i < 8; i++) begin
            if (kw_mask[i] && KW_SIZE[i] == int'(cmd_pos)) begin
                return 4'(i + 1);
            end
        end
        return KIND_NONE;
    endfunction

    // Queue one field byte unless the field is already full
    task automatic emit_field(input logic [1:0] tag, input logic [7:0] ch, input int limit);
        out_t w;
        if (int'(fld_cnt) < limit) begin
            w = '0;
            w.field_tag  = tag;
            w.field_byte = ch;
            event_words_due.push_back(w);
            fld_cnt = fld_cnt + 1'b1;
        end
    endtask

    // Close the line content: decide the kind once, then ignore further bytes
    task automatic settle_line();
        if (ph == PH_DONE) begin
            return;
        end
        if (ph == PH_CMD_WORD) begin
            kind_sel = match_keyword();
        end else if (ph == PH_START || ph == PH_CMD_SKIP ||
                     ph == PH_PFX_NICK || ph == PH_PFX_REST) begin
            kind_sel = KIND_NONE;
        end
        ph = PH_DONE;
    endtask

    task automatic eat_char(input logic [7:0] ch);
        if (ph == PH_START) begin
            if (ch == CH_COLON) begin
                ph = PH_PFX_NICK;
                return;
            end
            ph = PH_CMD_SKIP;
        end
        // Prefix: nick up to '!', the rest dropped, first space closes it
        if (ph == PH_PFX_NICK || ph == PH_PFX_REST) begin
            if (ch == CH_SPACE) begin
                fld_cnt = '0;
                ph = PH_CMD_SKIP;
            end else if (ph == PH_PFX_NICK) begin
                if (ch == CH_BANG) begin
                    ph = PH_PFX_REST;
                end else begin
                    emit_field(TAG_NICK, ch, NICK_LEN - 1);
                end
            end
            return;
        end
        if (ph == PH_CMD_SKIP) begin
            if (ch == CH_SPACE) begin
                return;
            end
            ph = PH_CMD_WORD;
        end
        // Command word: knock out keywords that disagree at this position
        if (ph == PH_CMD_WORD) begin
            if (ch == CH_SPACE) begin
                kind_sel = match_keyword();
                ph = (kind_sel == KIND_NONE) ? PH_DONE : PH_PAR_SKIP;
                return;
            end
            for (int i = 0; i < 8; i++) begin
                if (int'(cmd_pos) >= KW_SIZE[i]) begin
                    kw_mask[i] = 1'b0;
                end else if (KW_NAME[i][8 * (KW_SIZE[i] - 1 - int'(cmd_pos)) +: 8] != ch) begin
                    kw_mask[i] = 1'b0;
                end
            end
            if (cmd_pos < CMD_POS_MAX) begin
                cmd_pos = cmd_pos + 1'b1;
            end
            return;
        end
        if (ph == PH_PAR_SKIP) begin
            if (ch == CH_SPACE) begin
                return;
            end
            fld_cnt = '0;
            if (ch == CH_COLON) begin
                trail_seen = 1'b1;
                ph = PH_TRAIL;
                return;
            end
            ph = PH_TARGET;
        end
        if (ph == PH_TARGET) begin
            if (ch == CH_SPACE) begin
                ph = PH_TRL_SKIP;
                return;
            end
            emit_field(TAG_TARGET, ch, TARGET_LEN - 1);
            return;
        end
        if (ph == PH_TRL_SKIP) begin
            if (ch == CH_SPACE) begin
                return;
            end
            trail_seen = 1'b1;
            fld_cnt = '0;
            ph = PH_TRAIL;
            if (ch == CH_COLON) begin
                return;
            end
        end
        // Trailing text; for NICK it becomes the new target
        if (ph == PH_TRAIL) begin
            if (kind_sel == KIND_NICK) begin
                emit_field(TAG_RENAME, ch, TARGET_LEN - 1);
            end else begin
                emit_field(TAG_TEXT, ch, TEXT_LEN - 1);
            end
        end
    endtask

    // Predict every result word caused by one accepted input word
    task automatic parse_line_byte(input in_t w);
        int   before_cnt;
        out_t v;
        before_cnt = event_words_due.size();
        if (ph != PH_DONE) begin
            if (w.char_in == CH_NUL) begin
                settle_line();
            end else begin
                eat_char(w.char_in);
            end
        end
        if (w.end_of_line) begin
            settle_line();
            v = '0;
            v.is_verdict      = 1'b1;
            v.accepted        = (kind_sel != KIND_NONE);
            v.event_kind      = kind_sel;
            v.target_replaced = (kind_sel == KIND_NICK) && trail_seen;
            event_words_due.push_back(v);
            rewind_line();
        end
        // Mark the last word of this input
        if (event_words_due.size() > before_cnt) begin
            v = event_words_due.pop_back();
            v.run_end = 1'b1;
            event_words_due.push_back(v);
        end
    endtask

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic flag_error(input string msg);
        err_cnt++;
        $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task automatic cmp_field(input string name, input logic [7:0] got, input logic [7:0] want);
        if (got !== want) begin
            flag_error($sformatf("word %0d %s got 0x%0h expected 0x%0h",
                                 words_rcvd, name, got, want));
        end
    endtask

    task automatic check_word(input out_t got);
        out_t want;
        if (event_words_due.size() == 0) begin
            flag_error($sformatf("word %0d arrived with nothing expected (0x%0h)",
                                 words_rcvd, got));
            return;
        end
        want = event_words_due.pop_front();
        cmp_field("is_verdict",      8'(got.is_verdict),      8'(want.is_verdict));
        cmp_field("field_tag",       8'(got.field_tag),       8'(want.field_tag));
        cmp_field("field_byte",      got.field_byte,          want.field_byte);
        cmp_field("accepted",        8'(got.accepted),        8'(want.accepted));
        cmp_field("event_kind",      8'(got.event_kind),      8'(want.event_kind));
        cmp_field("target_replaced", 8'(got.target_replaced), 8'(want.target_replaced));
        cmp_field("run_end",         8'(got.run_end),         8'(want.run_end));
    endtask

    // Sample both handshakes at the rising edge; predict first, then check
    always @(posedge aclk) begin
        byte_taken <= aresetn && s_valid && s_ready;
        if (!aresetn) begin
            rewind_line();
        end else begin
            if (s_valid && s_ready) begin
                parse_line_byte(s_data);
            end
            if (m_valid && m_ready) begin
                check_word(m_data);
                words_rcvd <= words_rcvd + 1;
            end
        end
    end

    // Abort when neither side moves a word for too long
    int idle_cycles = 0;
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Driving: both sides change at the falling edge
    // ------------------------------------------------------------------

    // Mostly no gap, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    int tx_gap  = 0;
    int tx_calm = 0;
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !byte_taken) begin
            // hold the word until it is taken
        end else if (tx_gap > 0) begin
            s_valid <= 1'b0;
            tx_gap--;
        end else if (line_stream.size() != 0) begin
            s_data  <= line_stream.pop_front();
            s_valid <= 1'b1;
            if (tx_calm > 0) begin
                tx_calm--;
            end else begin
                tx_gap = pick_gap();
                if ($urandom_range(0, 99) < 3) begin
                    tx_calm = $urandom_range(40, 150);
                end
            end
        end else begin
            s_valid <= 1'b0;
        end
    end

    int rx_stall  = 0;
    int rx_calm   = 0;
    bit hold_done = 1'b0;
    always @(negedge aclk) begin
        logic rdy;
        if (!aresetn) begin
            rdy = 1'b0;
        end else if (rx_stall > 0) begin
            rdy = 1'b0;
            rx_stall--;
        end else if (!hold_done && words_rcvd >= HOLD_AT) begin
            // Hold off long enough for the block to fill and push back on the sender
            hold_done = 1'b1;
            rx_stall  = HOLD_CYCLES;
            rdy       = 1'b0;
        end else if (rx_calm > 0) begin
            rx_calm--;
            rdy = 1'b1;
        end else if ($urandom_range(0, 99) < 20) begin
            rx_stall = pick_gap();
            rdy      = 1'b0;
        end else begin
            rdy = 1'b1;
            if ($urandom_range(0, 99) < 2) begin
                rx_calm = $urandom_range(40, 150);
            end
        end
        m_ready <= rdy;
    end

    // ------------------------------------------------------------------
    // Line builders
    // ------------------------------------------------------------------

    // Hand the line over as words, flagging the last byte
    task automatic commit_line();
        in_t w;
        for (int i = 0; i < line_buf.size(); i++) begin
            w.char_in     = line_buf[i];
            w.end_of_line = (i == line_buf.size() - 1);
            line_stream.push_back(w);
        end
        stim_bytes += line_buf.size();
        line_buf.delete();
    endtask

    task automatic add_str(input string s);
        for (int i = 0; i < s.len(); i++) begin
            line_buf.push_back(s[i]);
        end
    endtask

    task automatic add_spaces(input int n);
        repeat (n) line_buf.push_back(CH_SPACE);
    endtask

    // Nonzero bytes; spaces only where the field may hold them
    task automatic add_word(input int len, input bit spaced);
        logic [7:0] ch;
        repeat (len) begin
            if (spaced && $urandom_range(0, 6) == 0) begin
                ch = CH_SPACE;
            end else begin
                ch = 8'($urandom_range(1, 254));
                if (ch >= CH_SPACE) ch = ch + 1'b1;
            end
            line_buf.push_back(ch);
        end
    endtask

    task automatic add_keyword(input int k, input int n);
        for (int p = 0; p < n; p++) begin
            line_buf.push_back(KW_NAME[k][8 * (KW_SIZE[k] - 1 - p) +: 8]);
        end
    endtask

    // Mostly short, now and then past the field limit
    function automatic int pick_len(input int common_max, input int long_lo, input int long_hi);
        if ($urandom_range(0, 99) < 5) return $urandom_range(long_lo, long_hi);
        return $urandom_range(0, common_max);
    endfunction

    // [:nick[!rest] ] COMMAND [target] [[ :]text]
    task automatic build_event_line();
        int r;
        int k;
        if ($urandom_range(0, 1) == 1) begin
            line_buf.push_back(CH_COLON);
            add_word(pick_len(8, 28, 40), 1'b0);
            if ($urandom_range(0, 1) == 1) begin
                line_buf.push_back(CH_BANG);
                add_word(pick_len(10, 10, 20), 1'b0);
            end
            add_spaces($urandom_range(1, 2));
        end
        r = $urandom_range(0, 99);
        k = $urandom_range(0, 7);
        if (r < 80) begin
            add_keyword(k, KW_SIZE[k]);
        end else if (r < 88) begin
            add_keyword(k, $urandom_range(0, KW_SIZE[k] - 1));
        end else if (r < 94) begin
            add_keyword(k, KW_SIZE[k]);
            add_word($urandom_range(1, 12), 1'b0);
        end else begin
            add_word($urandom_range(1, 20), 1'b0);
        end
        if ($urandom_range(0, 9) != 0) add_spaces($urandom_range(1, 3));
        if ($urandom_range(0, 9) != 0) add_word(pick_len(10, 60, 70), 1'b0);
        r = $urandom_range(0, 9);
        if (r < 4) begin
            add_spaces($urandom_range(1, 2));
            line_buf.push_back(CH_COLON);
            add_word(pick_len(12, 250, 270), 1'b1);
        end else if (r < 7) begin
            add_spaces($urandom_range(1, 2));
            add_word(pick_len(12, 250, 270), 1'b1);
        end else if (r == 7) begin
            add_spaces($urandom_range(1, 2));
        end
    endtask

    // Raw bytes biased toward the characters the parser reacts to
    task automatic build_noise_line();
        int r;
        repeat ($urandom_range(1, 20)) begin
            r = $urandom_range(0, 9);
            case (r)
                0: line_buf.push_back(CH_NUL);
                1: line_buf.push_back(CH_SPACE);
                2: line_buf.push_back(CH_COLON);
                3: line_buf.push_back(CH_BANG);
                default: line_buf.push_back(8'($urandom_range(0, 255)));
            endcase
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus, reset and end of run
    // ------------------------------------------------------------------
    initial begin
        int r;
        int keep;

        // Directed lines: NICK with prefix and trailing text after ':'
        add_str(":a!b NICK :c");
        commit_line();
        // Zero byte that is also the last byte
        line_buf.push_back(CH_NUL);
        commit_line();
        // Prefix never closed by a space
        add_str(":ab");
        commit_line();
        // Zero byte ends the content; the byte after it is dropped
        add_str("JOIN");
        line_buf.push_back(CH_NUL);
        line_buf.push_back(8'hFF);
        commit_line();
        // Unknown command with an all-ones byte
        add_str("Q");
        line_buf.push_back(8'hFF);
        commit_line();

        // Random lines: mostly well formed, some cut short, some noise
        while (stim_bytes < RANDOM_BYTES) begin
            r = $urandom_range(0, 99);
            if (r < 75) begin
                build_event_line();
            end else if (r < 88) begin
                build_event_line();
                if (line_buf.size() != 0) begin
                    keep = $urandom_range(1, line_buf.size());
                    while (line_buf.size() > keep) void'(line_buf.pop_back());
                end
            end else begin
                build_noise_line();
            end
            if (line_buf.size() != 0 && $urandom_range(0, 99) < 6) begin
                line_buf[$urandom_range(0, line_buf.size() - 1)] = CH_NUL;
            end
            commit_line();
        end

        // Hold reset, then release it at a falling edge
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Wait for every word to be taken and every prediction to be met
        while (line_stream.size() != 0 || s_valid) @(posedge aclk);
        while (event_words_due.size() != 0) @(posedge aclk);
        // Watch a little longer for stray words
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (err_cnt == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/irclep_pkg.sv
hw/rtl/irclep_core.sv
hw/rtl/irclep_queue.sv
hw/rtl/irc_line_event_parser.sv
tb/sv/irc_line_event_parser_test.sv
